/* rtl/core/number_to_ascii_formatter_defines.svh */
// Assertion helpers for the formatter; clocked on clk_i, off during reset.
`ifndef NUMBER_TO_ASCII_FORMATTER_DEFINES_SVH
`define NUMBER_TO_ASCII_FORMATTER_DEFINES_SVH

// same-cycle implication
`define NAFMT_ASSERT_NOW(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |-> (cons)) else $error(msg);

// next-cycle implication
`define NAFMT_ASSERT_NEXT(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |=> (cons)) else $error(msg);

`endif

/* rtl/core/nafmt_pkg.sv */
package nafmt_pkg;

  localparam int unsigned NumW   = 64;
  localparam int unsigned HalfW  = 32;
  localparam int unsigned OpW    = 2;
  localparam int unsigned CharW  = 8;
  localparam int unsigned DigW   = 4;
  localparam int unsigned PosW   = 5;

  // digit store: at most 10 decimal digits of a 32-bit value
  localparam int unsigned DigDepth = 10;
  localparam int unsigned StkIdxW  = $clog2(DigDepth);
  localparam int unsigned StkCntW  = $clog2(DigDepth + 1);

  // ceil(2^35 / 10): floor(x * Recip10 / 2^35) == x / 10 for any 32-bit x
  localparam logic [HalfW-1:0] Recip10 = 32'hCCCC_CCCD;
  localparam int unsigned      Recip10Shift = 35;

  localparam logic [CharW-1:0] ChZero = 8'h30;
  localparam logic [CharW-1:0] ChX    = 8'h78;

  // position of the final character: "0x" plus 8 or 16 digits
  localparam logic [PosW-1:0] HexLast32 = 5'd9;
  localparam logic [PosW-1:0] HexLast64 = 5'd17;

  typedef enum logic [OpW-1:0] {
    OP_DEC   = 2'd0,
    OP_HEX32 = 2'd1,
    OP_HEX64 = 2'd2,
    OP_NONE  = 2'd3
  } nafmt_op_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_DEC,
    S_HEX
  } nafmt_state_e;

  typedef struct packed {
    logic clr;
    logic push;
    logic pop;
  } nafmt_stk_ctrl_t;

  localparam logic [CharW-1:0] HexChars [16] = '{
    8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
    8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46
  };

  function automatic logic [CharW-1:0] hex_char(input logic [DigW-1:0] nib);
    return HexChars[nib];
  endfunction

endpackage

/* rtl/core/nafmt_if.sv */
// input channel: one number and its format code per item
interface nafmt_in_if;
  import nafmt_pkg::*;

  logic            valid;
  logic            ready;
  logic [NumW-1:0] number;
  logic [OpW-1:0]  opcode;

  modport source (output valid, number, opcode, input ready);
  modport sink   (input valid, number, opcode, output ready);
endinterface

// output channel: one character per item
interface nafmt_out_if;
  import nafmt_pkg::*;

  logic             valid;
  logic             ready;
  logic [CharW-1:0] char_code;
  logic             last_char;

  modport source (output valid, char_code, last_char, input ready);
  modport sink   (input valid, char_code, last_char, output ready);
endinterface

/* rtl/core/nafmt_div10.sv */
module nafmt_div10 (
  input  logic                        clk_i,
  input  logic                        load_i,
  input  logic [nafmt_pkg::HalfW-1:0] x_i,
  output logic [nafmt_pkg::HalfW-1:0] q_o,
  output logic [nafmt_pkg::DigW-1:0]  r_o
);
  import nafmt_pkg::*;

  logic [2*HalfW-1:0] prod_d, prod_q;
  logic [HalfW-1:0]   x_q;
  logic [HalfW-1:0]   q10;
  logic [HalfW-1:0]   diff;

  // reciprocal multiply, registered
  assign prod_d = x_i * Recip10;

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      prod_q <= prod_d;
      x_q    <= x_i;
    end
  end

  assign q_o  = {{Recip10Shift - HalfW{1'b0}}, prod_q[2*HalfW-1:Recip10Shift]};
  assign q10  = (q_o << 3) + (q_o << 1);
  assign diff = x_q - q10;
  assign r_o  = diff[DigW-1:0];

endmodule

/* rtl/core/nafmt_dstack.sv */
module nafmt_dstack (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  nafmt_pkg::nafmt_stk_ctrl_t    ctrl_i,
  input  logic [nafmt_pkg::DigW-1:0]    digit_i,
  output logic [nafmt_pkg::DigW-1:0]    top_o,
  output logic [nafmt_pkg::StkCntW-1:0] cnt_o
);
  import nafmt_pkg::*;

  logic [DigW-1:0]    mem_q [DigDepth];
  logic [StkCntW-1:0] cnt_d, cnt_q;
  logic [StkCntW-1:0] top_idx;

  always_comb begin
    cnt_d = cnt_q;
    if (ctrl_i.clr) begin
      cnt_d = '0;
    end else if (ctrl_i.push) begin
      cnt_d = cnt_q + 1'b1;
    end else if (ctrl_i.pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.push) begin
      mem_q[cnt_q[StkIdxW-1:0]] <= digit_i;
    end
  end

  assign top_idx = (cnt_q == '0) ? '0 : cnt_q - 1'b1;
  assign top_o   = mem_q[top_idx[StkIdxW-1:0]];
  assign cnt_o   = cnt_q;

endmodule

/* rtl/core/number_to_ascii_formatter.sv */
// Number to ASCII text formatter.
// in_i  : one item = 64-bit number plus format code (decimal, hex32, hex64).
//         A code with no meaning is taken and dropped without output.
// out_o : one item per character, most significant first; last_char marks
//         the final character of each number's text.
// Decimal prints the low 32 bits without leading zeros ("0" for zero).
// Hex prints "0x" and 8 or 16 uppercase digits, zero padded.
// Timing: in_i.ready is high only while idle. A decimal item produces one
// digit per cycle in the divide-by-10 loop (a 32x32 reciprocal multiply,
// registered), then one character per cycle while out_o is not stalled.
// A hex item gives one character per cycle while out_o is not stalled.
// Characters sit in a single output register; a stall on out_o freezes the
// sequencer, and the next item is taken as soon as the last character of
// the current one is loaded, even if it still waits to be taken.
// Reset (rst_ni low, async) returns to idle and drops any pending character.
module number_to_ascii_formatter (
  input  logic               clk_i,
  input  logic               rst_ni,
  nafmt_in_if.sink           in_i,
  nafmt_out_if.source        out_o
);
  import nafmt_pkg::*;

  `include "number_to_ascii_formatter_defines.svh"

  nafmt_state_e state_d, state_q;

  logic [NumW-1:0]  val_d, val_q;   // hex digits, next one in the top nibble
  logic             wide_d, wide_q;
  logic [PosW-1:0]  pos_d, pos_q;   // hex character position
  logic [CharW-1:0] och_d, och_q;
  logic             olast_d, olast_q;
  logic             ovalid_d, ovalid_q;

  logic             out_free;
  logic             div_load;
  logic [HalfW-1:0] div_x;
  logic [HalfW-1:0] div_q;
  logic [DigW-1:0]  div_r;

  nafmt_stk_ctrl_t    stk_ctrl;
  logic [DigW-1:0]    stk_top;
  logic [StkCntW-1:0] stk_cnt;

  nafmt_div10 u_div10 (
    .clk_i  (clk_i),
    .load_i (div_load),
    .x_i    (div_x),
    .q_o    (div_q),
    .r_o    (div_r)
  );

  // decimal digits come out low first; the stack reverses them
  nafmt_dstack u_dstack (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (stk_ctrl),
    .digit_i (div_r),
    .top_o   (stk_top),
    .cnt_o   (stk_cnt)
  );

  // output register can take a character this cycle
  assign out_free = !ovalid_q || out_o.ready;

  always_comb begin
    state_d  = state_q;
    val_d    = val_q;
    wide_d   = wide_q;
    pos_d    = pos_q;
    och_d    = och_q;
    olast_d  = olast_q;
    ovalid_d = ovalid_q && !out_o.ready;
    div_load = 1'b0;
    div_x    = div_q;
    stk_ctrl = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          unique case (nafmt_op_e'(in_i.opcode))
            OP_DEC: begin
              div_load     = 1'b1;
              div_x        = in_i.number[HalfW-1:0];
              stk_ctrl.clr = 1'b1;
              state_d      = S_DIV;
            end
            OP_HEX32: begin
              val_d   = {in_i.number[HalfW-1:0], {HalfW{1'b0}}};
              wide_d  = 1'b0;
              pos_d   = '0;
              state_d = S_HEX;
            end
            OP_HEX64: begin
              val_d   = in_i.number;
              wide_d  = 1'b1;
              pos_d   = '0;
              state_d = S_HEX;
            end
            OP_NONE: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end

      // one digit per cycle; stop once the quotient reaches zero
      S_DIV: begin
        stk_ctrl.push = 1'b1;
        if (div_q == '0) begin
          state_d = S_DEC;
        end else begin
          div_load = 1'b1;
        end
      end

      S_DEC: begin
        if (out_free) begin
          stk_ctrl.pop = 1'b1;
          ovalid_d     = 1'b1;
          och_d        = hex_char(stk_top);
          olast_d      = (stk_cnt == StkCntW'(1));
          if (stk_cnt == StkCntW'(1)) begin
            state_d = S_IDLE;
          end
        end
      end

      S_HEX: begin
        if (out_free) begin
          ovalid_d = 1'b1;
          pos_d    = pos_q + 1'b1;
          if (pos_q == '0) begin
            och_d = ChZero;
          end else if (pos_q == PosW'(1)) begin
            och_d = ChX;
          end else begin
            och_d = hex_char(val_q[NumW-1 -: DigW]);
            val_d = val_q << DigW;
          end
          olast_d = (pos_q == (wide_q ? HexLast64 : HexLast32));
          if (pos_q == (wide_q ? HexLast64 : HexLast32)) begin
            state_d = S_IDLE;
          end
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      pos_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      pos_q    <= pos_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q   <= val_d;
    wide_q  <= wide_d;
    och_q   <= och_d;
    olast_q <= olast_d;
  end

  assign in_i.ready      = (state_q == S_IDLE);
  assign out_o.valid     = ovalid_q;
  assign out_o.char_code = och_q;
  assign out_o.last_char = olast_q;

  // a decimal item starts the divide loop on an empty digit store
  `NAFMT_ASSERT_NEXT(a_dec_start,
    in_i.valid && in_i.ready && (in_i.opcode == OP_DEC),
    (state_q == S_DIV) && (stk_cnt == '0),
    "decimal item did not start divide loop")

  // a 32-bit value never yields more than ten digits
  `NAFMT_ASSERT_NOW(a_stk_room, state_q == S_DIV,
    stk_cnt < StkCntW'(DigDepth), "digit store overflow")

  // leaving the divide loop always leaves at least one digit to print
  `NAFMT_ASSERT_NEXT(a_dec_nonempty, (state_q == S_DIV) && (div_q == '0),
    (state_q == S_DEC) && (stk_cnt != '0), "no digits after divide loop")

  // final hex character is presented marked and the sequencer goes idle
  `NAFMT_ASSERT_NEXT(a_hex_last,
    (state_q == S_HEX) && out_free && (pos_q == (wide_q ? HexLast64 : HexLast32)),
    (state_q == S_IDLE) && out_o.valid && out_o.last_char,
    "hex text end not marked")

endmodule
